[sv/edge_interrupt_dispatcher_assert.svh]
// assertion macros used by the interrupt dispatcher back end
`ifndef EDGE_INTERRUPT_DISPATCHER_ASSERT_SVH
`define EDGE_INTERRUPT_DISPATCHER_ASSERT_SVH

// property that must hold at every clock edge outside reset
`define EID_ASSERT_HOLDS(lbl, expr) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error("dispatcher invariant violated");

// property whose consequent must hold in the cycle after the antecedent
`define EID_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("dispatcher sequence violated");

`endif

[sv/eid_pkg.sv]
// types and constants of the edge interrupt dispatcher
package eid_pkg;

    // field and register widths
    localparam int MASK_W     = 32;
    localparam int LINE_W     = 8;
    localparam int LINE_NUM_W = $clog2(MASK_W);
    localparam int STATUS_W   = 2;

    // command queue geometry
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // input function codes
    localparam logic FUNC_SET  = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    // configuration register indexes
    localparam logic REG_ENABLE  = 1'b0;
    localparam logic REG_HANDLER = 1'b1;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 2'd0,
        ST_BAD_LINE   = 2'd1,
        ST_FIRED      = 2'd2,
        ST_EMPTY_TICK = 2'd3
    } t_status;

    // command kinds passed from front to back
    typedef enum logic [1:0] {
        KIND_OK   = 2'd0,
        KIND_BAD  = 2'd1,
        KIND_TICK = 2'd2
    } t_kind;

    // one queued command: kind plus the lines that fired on a tick
    typedef struct packed {
        t_kind             kind;
        logic [MASK_W-1:0] fire;
    } t_cmd;

endpackage

[sv/eid_front.sv]
// front end: accepts items, keeps pending state and masks, builds commands
module eid_front #(
    parameter int LINE_COUNT = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_accept,
    input  logic                        i_func,
    input  logic [eid_pkg::LINE_W-1:0]  i_line,
    input  logic                        i_pending_level,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_index,
    input  logic [eid_pkg::MASK_W-1:0]  i_cfg_data,
    output logic                        o_push,
    output eid_pkg::t_cmd               o_cmd
);
    import eid_pkg::*;

    localparam int IDX_W = (LINE_COUNT > 1) ? $clog2(LINE_COUNT) : 1;
    localparam logic [LINE_W:0] LINE_LIMIT = (LINE_W + 1)'(LINE_COUNT);

    logic [LINE_COUNT-1:0] r_pend, n_pend;
    logic [LINE_COUNT-1:0] r_snap, n_snap;
    logic [MASK_W-1:0]     r_en;
    logic [MASK_W-1:0]     r_hp;
    logic [MASK_W-1:0]     w_pend_v;
    logic [MASK_W-1:0]     w_snap_v;
    logic [MASK_W-1:0]     w_lmask;
    logic                  w_line_ok;

    // register-width views of the line state, bits past the line count read zero
    for (genvar gi = 0; gi < MASK_W; gi++) begin : g_view
        if (gi < LINE_COUNT) begin : g_live
            assign w_pend_v[gi] = r_pend[gi];
            assign w_snap_v[gi] = r_snap[gi];
            assign w_lmask[gi]  = 1'b1;
        end else begin : g_dead
            assign w_pend_v[gi] = 1'b0;
            assign w_snap_v[gi] = 1'b0;
            assign w_lmask[gi]  = 1'b0;
        end
    end

    assign w_line_ok = ({1'b0, i_line} < LINE_LIMIT);

    // next pending bits and snapshot
    always_comb begin
        n_pend = r_pend;
        n_snap = r_snap;
        if (i_accept) begin
            if (i_func == FUNC_SET) begin
                if (w_line_ok) begin
                    n_pend[i_line[IDX_W-1:0]] = i_pending_level;
                end
            end else begin
                n_snap = r_pend;
            end
        end
    end

    // command for the back end
    always_comb begin
        o_push   = i_accept;
        o_cmd.fire = '0;
        if (i_func == FUNC_TICK) begin
            o_cmd.kind = KIND_TICK;
            o_cmd.fire = w_pend_v & ~w_snap_v & r_en & r_hp;
        end else if (w_line_ok) begin
            o_cmd.kind = KIND_OK;
        end else begin
            o_cmd.kind = KIND_BAD;
        end
    end

    // line state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
            r_snap <= '0;
        end else begin
            r_pend <= n_pend;
            r_snap <= n_snap;
        end
    end

    // configuration masks
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en <= w_lmask;
            r_hp <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_ENABLE:  r_en <= i_cfg_data & w_lmask;
                REG_HANDLER: r_hp <= i_cfg_data & w_lmask;
                default:     r_en <= r_en;
            endcase
        end
    end

endmodule

[sv/eid_queue.sv]
// two-entry command queue between front and back
module eid_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  eid_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_nonempty,
    output eid_pkg::t_cmd o_head
);
    import eid_pkg::*;

    t_cmd                r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]  r_wr_ptr;
    logic [Q_PTR_W-1:0]  r_rd_ptr;
    logic [Q_CNT_W-1:0]  r_count;
    logic                w_push;
    logic                w_pop;

    assign o_full     = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_nonempty = (r_count != '0);
    assign o_head     = r_mem[r_rd_ptr];
    assign w_push     = i_push && !o_full;
    assign w_pop      = i_pop && o_nonempty;

    // entry storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

[sv/eid_back.sv]
// back end: drains commands into result beats, one fired line per beat
`include "edge_interrupt_dispatcher_assert.svh"
module eid_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_nonempty,
    input  eid_pkg::t_cmd                  i_head,
    output logic                           o_pop,
    input  logic                           i_stall,
    output logic                           o_valid,
    output logic [eid_pkg::STATUS_W-1:0]   o_status,
    output logic [eid_pkg::LINE_NUM_W-1:0] o_fired_line,
    output logic                           o_last
);
    import eid_pkg::*;

    logic                  r_valid, n_valid;
    logic                  r_busy, n_busy;
    logic [MASK_W-1:0]     r_vec, n_vec;
    t_status               r_status, n_status;
    logic [LINE_NUM_W-1:0] r_fired_line, n_fired_line;
    logic                  r_last, n_last;
    logic                  w_load;
    logic [MASK_W-1:0]     w_src;
    logic [MASK_W-1:0]     w_rest;
    logic [LINE_NUM_W-1:0] w_hi;

    assign w_load = !r_valid || !i_stall;
    assign w_src  = r_busy ? r_vec : i_head.fire;

    // highest set line of the source vector
    always_comb begin
        w_hi = '0;
        for (int i = 0; i < MASK_W; i++) begin
            if (w_src[i]) begin
                w_hi = LINE_NUM_W'(i);
            end
        end
    end

    // lines still to report after this beat
    always_comb begin
        w_rest       = w_src;
        w_rest[w_hi] = 1'b0;
    end

    // result selection
    always_comb begin
        n_valid      = r_valid;
        n_busy       = r_busy;
        n_vec        = r_vec;
        n_status     = r_status;
        n_fired_line = r_fired_line;
        n_last       = r_last;
        o_pop        = 1'b0;
        if (w_load) begin
            n_fired_line = '0;
            n_last       = 1'b1;
            if (r_busy) begin
                n_valid      = 1'b1;
                n_status     = ST_FIRED;
                n_fired_line = w_hi;
                n_last       = (w_rest == '0);
                n_busy       = (w_rest != '0);
                n_vec        = w_rest;
            end else if (i_nonempty) begin
                o_pop   = 1'b1;
                n_valid = 1'b1;
                case (i_head.kind)
                    KIND_BAD: begin
                        n_status = ST_BAD_LINE;
                    end
                    KIND_TICK: begin
                        if (w_src == '0) begin
                            n_status = ST_EMPTY_TICK;
                        end else begin
                            n_status     = ST_FIRED;
                            n_fired_line = w_hi;
                            n_last       = (w_rest == '0);
                            n_busy       = (w_rest != '0);
                            n_vec        = w_rest;
                        end
                    end
                    default: begin
                        n_status = ST_OK;
                    end
                endcase
            end else begin
                n_valid = 1'b0;
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_busy  <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_busy  <= n_busy;
        end
    end

    // result payload and remaining lines
    always_ff @(posedge i_clk) begin
        r_vec        <= n_vec;
        r_status     <= n_status;
        r_fired_line <= n_fired_line;
        r_last       <= n_last;
    end

    assign o_valid      = r_valid;
    assign o_status     = r_status;
    assign o_fired_line = r_fired_line;
    assign o_last       = r_last;

    // checks
    `EID_ASSERT_HOLDS(a_busy_has_lines, r_busy |-> (r_vec != '0))
    `EID_ASSERT_HOLDS(a_single_beat_form, (r_valid && r_status != ST_FIRED) |-> (r_fired_line == '0 && r_last))
    `EID_ASSERT_HOLDS(a_more_lines_follow, (r_valid && r_status == ST_FIRED && !r_last) |-> r_busy)
    `EID_ASSERT_HOLDS(a_no_pop_mid_tick, r_busy |-> !o_pop)
    `EID_ASSERT_NEXT(a_busy_only_after_fired, ($rose(r_busy)), (r_valid && r_status == ST_FIRED))

endmodule

[sv/edge_interrupt_dispatcher.sv]
// top level of the edge interrupt dispatcher
// an accepted item is written into the command queue, and its first result beat is registered in the back end
// throughput: one beat per cycle when not stalled; a set-pending item is one beat, a tick one beat per fired line
// a tick with no fired line gives one beat; the back end drains one line per cycle unless i_stall holds it
// the front takes a new item whenever the two-entry command queue has room
// reset: synchronous, clears pending bits, snapshot, queue and output; masks to reset values
module edge_interrupt_dispatcher #(
    parameter int LINE_COUNT = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic                           i_func,
    input  logic [eid_pkg::LINE_W-1:0]     i_line,
    input  logic                           i_pending_level,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [eid_pkg::STATUS_W-1:0]   o_status,
    output logic [eid_pkg::LINE_NUM_W-1:0] o_fired_line,
    output logic                           o_last,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic                           i_cfg_index,
    input  logic [eid_pkg::MASK_W-1:0]     i_cfg_data
);
    import eid_pkg::*;

    logic w_full;
    logic w_nonempty;
    logic w_accept;
    logic w_push;
    logic w_pop;
    t_cmd w_cmd;
    t_cmd w_head;

    // input beat handshake
    assign o_stall     = w_full;
    assign w_accept    = i_valid && !w_full;
    assign o_cfg_ready = 1'b1;

    eid_front #(
        .LINE_COUNT (LINE_COUNT)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (w_accept),
        .i_func          (i_func),
        .i_line          (i_line),
        .i_pending_level (i_pending_level),
        .i_cfg_we        (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_push          (w_push),
        .o_cmd           (w_cmd)
    );

    eid_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_cmd      (w_cmd),
        .i_pop      (w_pop),
        .o_full     (w_full),
        .o_nonempty (w_nonempty),
        .o_head     (w_head)
    );

    eid_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_nonempty   (w_nonempty),
        .i_head       (w_head),
        .o_pop        (w_pop),
        .i_stall      (i_stall),
        .o_valid      (o_valid),
        .o_status     (o_status),
        .o_fired_line (o_fired_line),
        .o_last       (o_last)
    );

endmodule

[verif/tb_edge_interrupt_dispatcher.sv]
// self-checking testbench of the edge interrupt dispatcher
module tb_edge_interrupt_dispatcher;
    import eid_pkg::*;

    localparam int LINES       = 32;
    localparam int QUIET_LIMIT = 5000;

    // one request beat and one result beat
    typedef struct packed {
        logic              func;
        logic [LINE_W-1:0] line;
        logic              level;
    } t_irq_req;

    typedef struct packed {
        t_status               status;
        logic [LINE_NUM_W-1:0] line;
        logic                  last;
    } t_irq_beat;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    // request side
    logic              req_valid = 1'b0;
    logic              req_func = 1'b0;
    logic [LINE_W-1:0] req_line = '0;
    logic              req_level = 1'b0;
    logic              o_stall;

    // result side
    logic                  o_valid;
    logic                  rx_stall = 1'b0;
    logic [STATUS_W-1:0]   o_status;
    logic [LINE_NUM_W-1:0] o_fired_line;
    logic                  o_last;

    // register write side
    logic              cfg_valid = 1'b0;
    logic              cfg_index = 1'b0;
    logic [MASK_W-1:0] cfg_data = '0;
    logic              o_cfg_ready;

    // mirror of the block state
    logic [LINES-1:0] pend_bits = '0;
    logic [LINES-1:0] snap_bits = '0;
    logic [LINES-1:0] en_mask = '1;
    logic [LINES-1:0] hnd_mask = '0;

    t_irq_req  pending_reqs[$];
    t_irq_beat expected_beats[$];
    t_irq_req  req_cur;
    int        gap_left = 0;
    int        tx_calm = 0;
    int        stall_left = 0;
    int        rx_calm = 0;
    int        fail_count = 0;
    int        beat_count = 0;
    int        quiet_cycles = 0;

    edge_interrupt_dispatcher dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_valid         (req_valid),
        .o_stall         (o_stall),
        .i_func          (req_func),
        .i_line          (req_line),
        .i_pending_level (req_level),
        .o_valid         (o_valid),
        .i_stall         (rx_stall),
        .o_status        (o_status),
        .o_fired_line    (o_fired_line),
        .o_last          (o_last),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // idle length: mostly none or short, a few long, with calm stretches
    function automatic int idle_len(inout int calm);
        int pick;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        pick = $urandom_range(0, 99);
        if (pick < 2) calm = $urandom_range(10, 40);
        if (pick < 55) return 0;
        if (pick < 85) return $urandom_range(1, 3);
        if (pick < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR: %s", msg);
        fail_count++;
    endtask

    task automatic push_beat(input t_status st, input logic [LINE_NUM_W-1:0] ln,
                             input logic lst);
        t_irq_beat b;
        b.status = st;
        b.line   = ln;
        b.last   = lst;
        expected_beats.push_back(b);
    endtask

    // expected beats of one accepted request, updates the mirrored state
    task automatic dispatch_predict(input t_irq_req it);
        logic [LINES-1:0] fire;
        int               total;
        int               k;
        if (it.func == FUNC_SET) begin
            if (it.line >= LINES) begin
                push_beat(ST_BAD_LINE, '0, 1'b1);
            end else begin
                pend_bits[it.line[LINE_NUM_W-1:0]] = it.level;
                push_beat(ST_OK, '0, 1'b1);
            end
        end else begin
            fire  = ~snap_bits & pend_bits & en_mask & hnd_mask;
            total = $countones(fire);
            k     = 0;
            for (int i = LINES - 1; i >= 0; i--) begin
                if (fire[i]) begin
                    k++;
                    push_beat(ST_FIRED, i[LINE_NUM_W-1:0], k == total);
                end
            end
            if (total == 0) push_beat(ST_EMPTY_TICK, '0, 1'b1);
            snap_bits = pend_bits;
        end
    endtask

    // request driver
    always @(posedge clk) begin
        if (!rst_n) begin
            req_valid <= 1'b0;
            gap_left = 0;
        end else begin
            if (req_valid && !o_stall) dispatch_predict(req_cur);
            if (!req_valid || !o_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    req_valid <= 1'b0;
                    req_line  <= LINE_W'($urandom);
                end else if (pending_reqs.size() != 0) begin
                    req_cur = pending_reqs.pop_front();
                    req_valid <= 1'b1;
                    req_func  <= req_cur.func;
                    req_line  <= req_cur.line;
                    req_level <= req_cur.level;
                    gap_left = idle_len(tx_calm);
                end else begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor with random stall
    always @(posedge clk) begin
        t_irq_beat want;
        if (rst_n) begin
            if (o_valid && !rx_stall) begin
                beat_count++;
                if (expected_beats.size() == 0) begin
                    report_mismatch($sformatf("beat %0d with nothing expected: st %0d ln %0d",
                                              beat_count, o_status, o_fired_line));
                end else begin
                    want = expected_beats.pop_front();
                    if (o_status !== want.status || o_fired_line !== want.line ||
                        o_last !== want.last)
                        report_mismatch($sformatf(
                            "beat %0d: st %0d/%0d line %0d/%0d last %0d/%0d (got/exp)",
                            beat_count, o_status, want.status, o_fired_line, want.line,
                            o_last, want.last));
                end
            end
            if (stall_left == 0) stall_left = idle_len(rx_calm);
            rx_stall <= (stall_left != 0);
            if (stall_left != 0) stall_left--;
        end
    end

    // watchdog on cycles without any beat
    always @(posedge clk) begin
        if ((req_valid && !o_stall) || (o_valid && !rx_stall) || (cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAIL edge_interrupt_dispatcher");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic push_req(input logic fn, input logic [LINE_W-1:0] ln, input logic lv);
        t_irq_req r;
        r.func  = fn;
        r.line  = ln;
        r.level = lv;
        pending_reqs.push_back(r);
    endtask

    task automatic write_reg(input logic idx, input logic [MASK_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!o_cfg_ready);
        cfg_valid <= 1'b0;
        cfg_data  <= $urandom;
        if (idx == REG_ENABLE) en_mask = val;
        else hnd_mask = val;
    endtask

    // wait until every request went in and every beat came out
    task automatic drain();
        do @(negedge clk);
        while (pending_reqs.size() != 0 || req_valid || expected_beats.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    // random traffic, mostly bursts of set-pending closed by a tick
    task automatic fill_random(input int budget);
        int made;
        int pick;
        int burst;
        made = 0;
        while (made < budget) begin
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                burst = $urandom_range(1, 8);
                repeat (burst)
                    push_req(FUNC_SET, LINE_W'($urandom_range(0, LINES - 1)),
                             $urandom_range(0, 99) < 65);
                push_req(FUNC_TICK, LINE_W'($urandom), 1'($urandom));
                made += burst + 1;
            end else if (pick < 75) begin
                push_req(FUNC_TICK, LINE_W'($urandom), 1'($urandom));
                made++;
            end else if (pick < 85) begin
                push_req(FUNC_SET, LINE_W'($urandom_range(LINES, 255)), 1'($urandom));
                made++;
            end else if (pick < 97) begin
                push_req(FUNC_SET, LINE_W'($urandom_range(0, LINES - 1)), 1'($urandom));
                made++;
            end else begin
                // clear every line, tick, raise every line, tick: every enabled line with a handler fires
                for (int n = 0; n < LINES; n++) push_req(FUNC_SET, LINE_W'(n), 1'b0);
                push_req(FUNC_TICK, 8'd0, 1'b0);
                for (int n = LINES - 1; n >= 0; n--) push_req(FUNC_SET, LINE_W'(n), 1'b1);
                push_req(FUNC_TICK, 8'hff, 1'b1);
                made += 2 * LINES + 2;
            end
        end
    endtask

    initial begin
        logic [MASK_W-1:0] en_val;
        logic [MASK_W-1:0] hnd_val;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset masks: no handlers, so every tick is empty; bad line numbers
        push_req(FUNC_SET, 8'd31, 1'b1);
        push_req(FUNC_SET, 8'd0, 1'b1);
        push_req(FUNC_SET, 8'd32, 1'b1);
        push_req(FUNC_SET, 8'd255, 1'b0);
        push_req(FUNC_TICK, 8'd0, 1'b0);
        push_req(FUNC_TICK, 8'd0, 1'b0);
        drain();

        write_reg(REG_HANDLER, '1);
        write_reg(REG_ENABLE, '1);
        @(negedge clk);
        // rising edges fire high to low, ignored tick fields, level toggles between ticks
        push_req(FUNC_SET, 8'd0, 1'b0);
        push_req(FUNC_SET, 8'd31, 1'b0);
        push_req(FUNC_TICK, 8'd0, 1'b0);
        push_req(FUNC_SET, 8'd31, 1'b1);
        push_req(FUNC_SET, 8'd0, 1'b1);
        push_req(FUNC_SET, 8'd5, 1'b1);
        push_req(FUNC_TICK, 8'd0, 1'b0);
        push_req(FUNC_TICK, 8'd255, 1'b1);
        push_req(FUNC_SET, 8'd5, 1'b0);
        push_req(FUNC_SET, 8'd5, 1'b1);
        push_req(FUNC_TICK, 8'd3, 1'b0);
        push_req(FUNC_SET, 8'd7, 1'b1);
        push_req(FUNC_SET, 8'd200, 1'b1);
        push_req(FUNC_TICK, 8'd0, 1'b1);
        drain();

        // random phases over a range of mask settings
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: begin en_val = '1;       hnd_val = '1;       end
                1: begin en_val = '0;       hnd_val = '1;       end
                2: begin en_val = '1;       hnd_val = $urandom; end
                3: begin en_val = $urandom; hnd_val = $urandom; end
                4: begin en_val = $urandom; hnd_val = '0;       end
                default: begin en_val = $urandom | $urandom; hnd_val = $urandom | $urandom; end
            endcase
            write_reg(REG_ENABLE, en_val);
            write_reg(REG_HANDLER, hnd_val);
            @(negedge clk);
            fill_random(60);
            drain();
        end

        if (fail_count == 0) begin
            $display("PASS edge_interrupt_dispatcher");
        end else begin
            $display("FAIL edge_interrupt_dispatcher");
        end
        $finish;
    end
endmodule

[sim.f]
+incdir+sv
sv/eid_pkg.sv
sv/eid_front.sv
sv/eid_queue.sv
sv/eid_back.sv
sv/edge_interrupt_dispatcher.sv
verif/tb_edge_interrupt_dispatcher.sv
